>>> rtl/core/rotation_matrix_to_quaternion_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion core
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH
`ifndef SYNTH
// Check that a condition implies a same-cycle consequence.
`define RMQ_ASSERT_IMP(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (cons)) else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define RMQ_ASSERT_NXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (cons)) else $error(msg);
`else
`define RMQ_ASSERT_IMP(label, cond, cons, msg)
`define RMQ_ASSERT_NXT(label, cond, cons, msg)
`endif
`endif

>>> rtl/core/rmq_pkg.sv
// ---------------------------------------------------------------------------
// rmq_pkg
// Types, constants and per-stage step functions for the quaternion core.
// ---------------------------------------------------------------------------
package rmq_pkg;

    localparam int SQ_STEPS = 16;   // root bits, one per stage
    localparam int DV_STEPS = 15;   // quotient bits below the saturation point
    localparam logic signed [17:0] Q_ONE = 18'sd16384;
    localparam logic [31:0] SAFE_RAD = 32'd16384;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    typedef struct packed {
        branch_t         branch;
        logic            inval;
        logic [2:0][16:0] num;      // signed numerators of the off components
        logic [31:0]     rad;       // radicand bits still to be consumed
        logic [18:0]     rem;
        logic [15:0]     root;
    } sq_stage_t;

    typedef struct packed {
        branch_t         branch;
        logic            inval;
        logic [15:0]     root;
        logic [2:0]      neg;
        logic [2:0]      ovf;
        logic [2:0][15:0] rem;
        logic [2:0][14:0] low;      // dividend bits still to be consumed
        logic [2:0][14:0] quo;
    } dv_stage_t;

    // One bit of a digit-by-digit square root.
    function automatic sq_stage_t sqrt_step(input sq_stage_t cur);
        sq_stage_t  nxt;
        logic [18:0] acc;
        logic [18:0] trial;
        nxt   = cur;
        acc   = {cur.rem[16:0], cur.rad[31:30]};
        trial = {1'b0, cur.root, 2'b01};
        nxt.rad = {cur.rad[29:0], 2'b00};
        if (acc >= trial) begin
            nxt.rem  = acc - trial;
            nxt.root = {cur.root[14:0], 1'b1};
        end else begin
            nxt.rem  = acc;
            nxt.root = {cur.root[14:0], 1'b0};
        end
        return nxt;
    endfunction

    // One quotient bit of a restoring division, for each of the three lanes.
    function automatic dv_stage_t div_step(input dv_stage_t cur);
        dv_stage_t  nxt;
        logic [16:0] acc;
        nxt = cur;
        for (int i = 0; i < 3; i++) begin
            acc = {cur.rem[i], cur.low[i][14]};
            nxt.low[i] = {cur.low[i][13:0], 1'b0};
            if (acc >= {1'b0, cur.root}) begin
                nxt.rem[i] = 16'(acc - {1'b0, cur.root});
                nxt.quo[i] = {cur.quo[i][13:0], 1'b1};
            end else begin
                nxt.rem[i] = acc[15:0];
                nxt.quo[i] = {cur.quo[i][13:0], 1'b0};
            end
        end
        return nxt;
    endfunction

    // Apply sign and saturation to one quotient.
    function automatic logic [15:0] sat_quot(input logic neg, input logic ovf,
                                             input logic [14:0] quo);
        logic [15:0] val;
        if (ovf) begin
            val = neg ? 16'h8000 : 16'h7fff;
        end else begin
            val = neg ? 16'(-{1'b0, quo}) : {1'b0, quo};
        end
        return val;
    endfunction

endpackage

>>> rtl/core/rotation_matrix_to_quaternion_core.sv
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Shepperd conversion of a Q2.14 rotation matrix to a saturated Q2.14
// quaternion, fully pipelined.
// ---------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | nine matrix elements, 144 bits
//  m_axis   | out       | quaternion x, y, z, w and branch / invalid flags
//
//  The pipe has one setup stage, 16 square-root stages (one root bit
//  each), one divider setup stage, 15 restoring-division stages (one
//  quotient bit each, three lanes) and the output register.
//  One transfer per cycle is sustained. All stages hold together when the
//  output register is full and not taken. Reset clears the valid bits only.
// ---------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_core_defines.svh"

module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m_r1c1, m_r1c2, m_r1c3, m_r2c1, m_r2c2, m_r2c3, m_r3c1, m_r3c2, m_r3c3
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [63:0]  m_tdata,
    // branch_used[1:0], invalid
    output logic [2:0]   m_tuser
);

    logic adv;

    logic signed [15:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
    logic signed [17:0] trace;
    logic signed [17:0] arg;
    logic signed [16:0] d_zy, d_xz, d_yx, s_xy, s_xz, s_yz;
    sq_stage_t          setup;

    sq_stage_t sq_reg     [SQ_STEPS+1];
    logic      sq_vld_reg [SQ_STEPS+1];
    dv_stage_t dv_reg     [DV_STEPS+1];
    logic      dv_vld_reg [DV_STEPS+1];
    dv_stage_t dv_setup;

    logic [15:0] c0, c1, c2, big;
    logic [63:0] out_next;
    logic [63:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic        out_vld_reg;

    // Advance the whole pipe unless a finished result is stuck at the output.
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    assign m11 = s_tdata[15:0];
    assign m12 = s_tdata[31:16];
    assign m13 = s_tdata[47:32];
    assign m21 = s_tdata[63:48];
    assign m22 = s_tdata[79:64];
    assign m23 = s_tdata[95:80];
    assign m31 = s_tdata[111:96];
    assign m32 = s_tdata[127:112];
    assign m33 = s_tdata[143:128];

    // Setup: pick the form, build the root argument and the numerators.
    always_comb begin
        d_zy  = 17'(m32) - 17'(m23);
        d_xz  = 17'(m13) - 17'(m31);
        d_yx  = 17'(m21) - 17'(m12);
        s_xy  = 17'(m12) + 17'(m21);
        s_xz  = 17'(m13) + 17'(m31);
        s_yz  = 17'(m23) + 17'(m32);
        trace = 18'(m11) + 18'(m22) + 18'(m33);
        setup = '0;
        if (trace > 18'sd0) begin
            setup.branch = BR_TRACE;
            arg          = Q_ONE + trace;
            setup.num    = {d_yx, d_xz, d_zy};          // x, y, z
        end else if (m11 > m22 && m11 > m33) begin
            setup.branch = BR_X;
            arg          = Q_ONE + 18'(m11) - 18'(m22) - 18'(m33);
            setup.num    = {d_zy, s_xz, s_xy};          // y, z, w
        end else if (m22 > m33) begin
            setup.branch = BR_Y;
            arg          = Q_ONE + 18'(m22) - 18'(m11) - 18'(m33);
            setup.num    = {d_xz, s_yz, s_xy};          // x, z, w
        end else begin
            setup.branch = BR_Z;
            arg          = Q_ONE + 18'(m33) - 18'(m11) - 18'(m22);
            setup.num    = {d_yx, s_yz, s_xz};          // x, y, w
        end
        setup.inval = (arg <= 18'sd0);
        // Feed a harmless radicand on invalid items so the divisor stays nonzero.
        setup.rad   = setup.inval ? SAFE_RAD : {1'b0, arg[16:0], 14'b0};
    end

    // Divider setup: fold the saturation test into the first remainder.
    always_comb begin
        logic [16:0] mag;
        dv_setup        = '0;
        dv_setup.branch = sq_reg[SQ_STEPS].branch;
        dv_setup.inval  = sq_reg[SQ_STEPS].inval;
        dv_setup.root   = sq_reg[SQ_STEPS].root;
        for (int i = 0; i < 3; i++) begin
            dv_setup.neg[i] = sq_reg[SQ_STEPS].num[i][16];
            mag = dv_setup.neg[i] ? 17'(-sq_reg[SQ_STEPS].num[i])
                                  : sq_reg[SQ_STEPS].num[i];
            dv_setup.rem[i] = 16'(mag >> 2);
            dv_setup.low[i] = {mag[1:0], 13'b0};
            dv_setup.ovf[i] = (16'(mag >> 2) >= sq_reg[SQ_STEPS].root);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg[0] <= setup;
            for (int k = 0; k < SQ_STEPS; k++) begin
                sq_reg[k+1] <= sqrt_step(sq_reg[k]);
            end
            dv_reg[0] <= dv_setup;
            for (int k = 0; k < DV_STEPS; k++) begin
                dv_reg[k+1] <= div_step(dv_reg[k]);
            end
            out_data_reg <= out_next;
            out_user_reg <= {dv_reg[DV_STEPS].inval, dv_reg[DV_STEPS].branch};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= SQ_STEPS; k++) sq_vld_reg[k] <= 1'b0;
            for (int k = 0; k <= DV_STEPS; k++) dv_vld_reg[k] <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            sq_vld_reg[0] <= s_tvalid;
            for (int k = 0; k < SQ_STEPS; k++) sq_vld_reg[k+1] <= sq_vld_reg[k];
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
            for (int k = 0; k < DV_STEPS; k++) dv_vld_reg[k+1] <= dv_vld_reg[k];
            out_vld_reg <= dv_vld_reg[DV_STEPS];
        end
    end

    // Output: saturate quotients, place them by form and zero invalid results.
    always_comb begin
        c0  = sat_quot(dv_reg[DV_STEPS].neg[0], dv_reg[DV_STEPS].ovf[0],
                       dv_reg[DV_STEPS].quo[0]);
        c1  = sat_quot(dv_reg[DV_STEPS].neg[1], dv_reg[DV_STEPS].ovf[1],
                       dv_reg[DV_STEPS].quo[1]);
        c2  = sat_quot(dv_reg[DV_STEPS].neg[2], dv_reg[DV_STEPS].ovf[2],
                       dv_reg[DV_STEPS].quo[2]);
        big = {1'b0, dv_reg[DV_STEPS].root[15:1]};
        case (dv_reg[DV_STEPS].branch)
            BR_TRACE: out_next = {big, c2, c1, c0};
            BR_X:     out_next = {c2, c1, c0, big};
            BR_Y:     out_next = {c2, c1, big, c0};
            BR_Z:     out_next = {c2, big, c1, c0};
            default:  out_next = '0;
        endcase
        if (dv_reg[DV_STEPS].inval) begin
            out_next = '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `RMQ_ASSERT_IMP(a_inval_zero, m_tvalid && m_tuser[2], m_tdata == 64'd0, "invalid with data")
    `RMQ_ASSERT_IMP(a_trace_valid, m_tvalid && m_tuser[1:0] == BR_TRACE, !m_tuser[2], "trace invalid")
    `RMQ_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, sq_vld_reg[0], "transfer lost")

endmodule

>>> sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Streams Q2.14 rotation matrices into the quaternion core with random
// gaps and stalls on both sides, and checks every result field against
// a behavioral prediction of the Shepperd conversion.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import rmq_pkg::*;

    typedef struct packed {
        logic signed [15:0] qx, qy, qz, qw;
        branch_t            branch;
        logic               inval;
    } quat_t;

    // Predict quaternions and hold them until the core delivers them.
    class quat_scoreboard;
        quat_t pending[$];
        int    errors = 0;

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res = 0;
            longint unsigned b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        static function logic signed [15:0] scaled_quot(int n, longint unsigned r);
            longint unsigned mag;
            longint q;
            mag = longint'(n < 0 ? -n : n) * 8192;
            q = longint'(mag / r);
            if (n < 0) q = -q;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return 16'(q);
        endfunction

        function void note_matrix(logic [143:0] d);
            int m[9];
            int tr, arg;
            longint unsigned r, h;
            quat_t e;
            for (int i = 0; i < 9; i++) m[i] = int'($signed(d[16*i +: 16]));
            e = '0;
            tr = m[0] + m[4] + m[8];
            if (tr > 0) begin
                e.branch = BR_TRACE; arg = 16384 + tr;
            end else if (m[0] > m[4] && m[0] > m[8]) begin
                e.branch = BR_X; arg = 16384 + m[0] - m[4] - m[8];
            end else if (m[4] > m[8]) begin
                e.branch = BR_Y; arg = 16384 + m[4] - m[0] - m[8];
            end else begin
                e.branch = BR_Z; arg = 16384 + m[8] - m[0] - m[4];
            end
            if (arg <= 0) begin
                e.inval = 1'b1;
            end else begin
                r = int_sqrt(longint'(arg) * 16384);
                h = r >> 1;
                if (h > 32767) h = 32767;
                case (e.branch)
                    BR_TRACE: begin
                        e.qw = 16'(h);
                        e.qx = scaled_quot(m[7] - m[5], r);
                        e.qy = scaled_quot(m[2] - m[6], r);
                        e.qz = scaled_quot(m[3] - m[1], r);
                    end
                    BR_X: begin
                        e.qw = scaled_quot(m[7] - m[5], r);
                        e.qx = 16'(h);
                        e.qy = scaled_quot(m[1] + m[3], r);
                        e.qz = scaled_quot(m[2] + m[6], r);
                    end
                    BR_Y: begin
                        e.qw = scaled_quot(m[2] - m[6], r);
                        e.qx = scaled_quot(m[1] + m[3], r);
                        e.qy = 16'(h);
                        e.qz = scaled_quot(m[5] + m[7], r);
                    end
                    default: begin
                        e.qw = scaled_quot(m[3] - m[1], r);
                        e.qx = scaled_quot(m[2] + m[6], r);
                        e.qy = scaled_quot(m[5] + m[7], r);
                        e.qz = 16'(h);
                    end
                endcase
            end
            pending.push_back(e);
        endfunction

        function void check_quat(logic [63:0] d, logic [2:0] u);
            quat_t e;
            if (pending.size() == 0) begin
                $error("result with no matrix pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[15:0] !== e.qx) begin
                $error("quat_x expected %0d got %0d", e.qx, $signed(d[15:0])); errors++;
            end
            if (d[31:16] !== e.qy) begin
                $error("quat_y expected %0d got %0d", e.qy, $signed(d[31:16])); errors++;
            end
            if (d[47:32] !== e.qz) begin
                $error("quat_z expected %0d got %0d", e.qz, $signed(d[47:32])); errors++;
            end
            if (d[63:48] !== e.qw) begin
                $error("quat_w expected %0d got %0d", e.qw, $signed(d[63:48])); errors++;
            end
            if (u[1:0] !== e.branch) begin
                $error("branch_used expected %0d got %0d", e.branch, u[1:0]); errors++;
            end
            if (u[2] !== e.inval) begin
                $error("invalid expected %0d got %0d", e.inval, u[2]); errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;      // m_r1c1 .. m_r3c3, 16 bits each from bit 0
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;           // quat_x, quat_y, quat_z, quat_w
    logic [2:0]   m_tuser;           // branch_used[1:0], invalid

    quat_scoreboard sb = new();
    int   idle_cycles = 0;
    localparam int IDLE_LIMIT = 5000;

    rotation_matrix_to_quaternion_core DUT (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // No gap half the time, else mostly a short one and now and then a long one.
    function automatic int gap_len();
        int p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Watchdog on accepted transfers on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Sample results and note accepted matrices at the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_matrix(s_tdata);
            if (m_tvalid && m_tready) sb.check_quat(m_tdata, m_tuser);
        end
    end

    // Receiver: random stalls, with no-stall stretches.
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            g = gap_len();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // Send one matrix; valid stays high across back-to-back transfers.
    task automatic send_matrix(logic [143:0] d, bit with_gaps);
        int g = with_gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [143:0] pack_m(int a, int b, int c, int d, int e,
                                            int f, int g, int h, int i);
        return {16'(i), 16'(h), 16'(g), 16'(f), 16'(e), 16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    // Near-rotation matrix: strong diagonal pattern plus small noise.
    function automatic logic [143:0] rand_rot();
        int v[9];
        int pick = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++) v[i] = $urandom_range(0, 8000) - 4000;
        case (pick)
            0: begin v[0] += 12000; v[4] += 12000; v[8] += 12000; end
            1: begin v[0] += 14000; v[4] -= 14000; v[8] -= 14000; end
            2: begin v[0] -= 14000; v[4] += 14000; v[8] -= 14000; end
            default: begin v[0] -= 14000; v[4] -= 14000; v[8] += 14000; end
        endcase
        return pack_m(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    endfunction

    initial begin
        logic [143:0] d;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: identity, half-turns, ties and extremes.
        send_matrix(pack_m(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 0);
        send_matrix(pack_m(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 0);
        send_matrix(pack_m(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 0);
        send_matrix(pack_m(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 0);
        send_matrix(pack_m(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_matrix(pack_m(-100, 5, 5, 5, -100, 5, 5, 5, -100), 0);
        send_matrix(pack_m(-100, 0, 0, 0, -100, 0, 0, 0, -200), 0);
        send_matrix(pack_m(-200, 0, 0, 0, -100, 0, 0, 0, -100), 0);
        send_matrix(pack_m(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 1);
        send_matrix(pack_m(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                           32767), 1);
        send_matrix(pack_m(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
                           -32768), 1);
        send_matrix(pack_m(1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0), 1);
        send_matrix(pack_m(0, -32768, 32767, 32767, -20000, -32768, -32768, 32767,
                           -20000), 1);
        send_matrix(pack_m(-16384, -32768, -32768, -32768, -16384, -32768, -32768,
                           -32768, 32767), 1);
        send_matrix({144{1'b1}}, 1);
        send_matrix({9{16'h8000}}, 1);
        send_matrix({9{16'h7fff}}, 1);

        // Hold off until every result is back.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);

        for (int n = 0; n < 1200; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'($urandom);
            end else begin
                d = rand_rot();
            end
            send_matrix(d, 1);
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
